### sv/vitd_pkg.sv
package vitd_pkg;

    localparam int DEF_MAX_POSITIONS   = 4096;
    localparam int DEF_MAX_VERTICES    = 8192;
    localparam int DEF_ATTR_INDEX_BITS = 16;

    localparam int POSITION_COUNT_RESET = 4096;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LINK,
        ST_EMIT
    } state_t;

endpackage

### sv/vertex_index_triple_dedup.sv
// Steps: an accepted request reads its home entry and the duplicate chain (READ), an append
// links the new entry to the chain tail (LINK), and the result then goes out (EMIT);
// out-of-range positions go straight to EMIT. The entry table has a single read port, and in_stall
// is high until a request's result is loaded into the output register.
// Reset and every position_count write start a clearing pass over the min(MAX_POSITIONS, MAX_VERTICES)
// home entries (4096 by default), during which in_stall is high.
module vertex_index_triple_dedup #(
    parameter int MAX_POSITIONS   = vitd_pkg::DEF_MAX_POSITIONS,
    parameter int MAX_VERTICES    = vitd_pkg::DEF_MAX_VERTICES,
    parameter int ATTR_INDEX_BITS = vitd_pkg::DEF_ATTR_INDEX_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [$clog2(MAX_POSITIONS)-1:0]       pos_index,
    input  logic signed [ATTR_INDEX_BITS:0]        uv_index,
    input  logic signed [ATTR_INDEX_BITS:0]        normal_index,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [$clog2(MAX_VERTICES)-1:0]        vertex_id,
    output logic                                   created,
    output logic [1:0]                             status,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [$clog2(MAX_POSITIONS+1)-1:0]     position_count
);

    import vitd_pkg::*;

    localparam int POS_W  = $clog2(MAX_POSITIONS);
    localparam int ID_W   = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_POSITIONS + 1);
    localparam int NF_W   = $clog2(MAX_VERTICES + 1);
    localparam int ATTR_W = ATTR_INDEX_BITS + 1;

    localparam int HOME_DEPTH = (MAX_POSITIONS < MAX_VERTICES) ? MAX_POSITIONS : MAX_VERTICES;
    localparam int CLR_W      = (HOME_DEPTH > 1) ? $clog2(HOME_DEPTH) : 1;
    localparam int EFF_RESET  = (POSITION_COUNT_RESET > HOME_DEPTH) ? HOME_DEPTH
                                                                    : POSITION_COUNT_RESET;

    localparam int NRM_LSB  = 0;
    localparam int UV_LSB   = ATTR_W;
    localparam int POS_LSB  = 2 * ATTR_W;
    localparam int NEXT_LSB = POS_LSB + POS_W;
    localparam int HAS_BIT  = NEXT_LSB + ID_W;
    localparam int USED_BIT = HAS_BIT + 1;
    localparam int WORD_W   = USED_BIT + 1;

    state_t               state_reg, state_next;
    logic [CLR_W-1:0]     clr_reg;
    logic [CNT_W-1:0]     eff_count_reg;
    logic [NF_W-1:0]      next_free_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [ATTR_W-1:0]    uv_reg;
    logic [ATTR_W-1:0]    nrm_reg;
    logic [ID_W-1:0]      cur_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [ID_W-1:0]      res_id_reg;
    logic                 res_created_reg;
    status_t              res_status_reg;
    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic                 out_created_reg;
    status_t              out_status_reg;

    logic                 ram_we;
    logic [ID_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [ID_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic                 cfg_write;
    logic                 accept;
    logic                 in_range;
    logic                 clr_last;
    logic                 emit_load;
    logic                 ent_used;
    logic                 ent_has_next;
    logic [ATTR_W-1:0]    ent_uv;
    logic [ATTR_W-1:0]    ent_nrm;
    logic                 uv_ok;
    logic                 nrm_ok;
    logic                 ent_hit;
    logic                 do_claim;
    logic                 do_hit;
    logic                 do_follow;
    logic                 do_miss;
    logic                 table_full;
    logic [WORD_W-1:0]    new_word;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign in_range  = CNT_W'(pos_index) < eff_count_reg;
    assign clr_last  = (clr_reg == CLR_W'(HOME_DEPTH - 1));
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    assign ent_used     = ram_rdata[USED_BIT];
    assign ent_has_next = ram_rdata[HAS_BIT];
    assign ent_uv       = ram_rdata[UV_LSB +: ATTR_W];
    assign ent_nrm      = ram_rdata[NRM_LSB +: ATTR_W];
    assign uv_ok  = (ent_uv == '1) || (uv_reg == '1) || (ent_uv == uv_reg);
    assign nrm_ok = (ent_nrm == '1) || (nrm_reg == '1) || (ent_nrm == nrm_reg);
    assign ent_hit = (ram_rdata[POS_LSB +: POS_W] == pos_reg) && uv_ok && nrm_ok;

    assign do_claim  = (state_reg == ST_READ) && !ent_used;
    assign do_hit    = (state_reg == ST_READ) && ent_used && ent_hit;
    assign do_follow = (state_reg == ST_READ) && ent_used && !ent_hit && ent_has_next;
    assign do_miss   = (state_reg == ST_READ) && ent_used && !ent_hit && !ent_has_next;
    assign table_full = next_free_reg >= NF_W'(MAX_VERTICES);

    assign new_word = {1'b1, 1'b0, {ID_W{1'b0}}, pos_reg, uv_reg, nrm_reg};

    vitd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_vitd_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_range ? ST_READ : ST_EMIT;
                end
            end
            ST_READ:
            begin
                if (do_miss && !table_full)
                begin
                    state_next = ST_LINK;
                end
                else if (!do_follow)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_LINK:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_write)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = new_word;
        ram_raddr = ID_W'(pos_index);
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ID_W'(clr_reg);
                ram_wdata = '0;
            end
            ST_READ:
            begin
                ram_raddr = ram_rdata[NEXT_LSB +: ID_W];
                if (do_claim)
                begin
                    ram_we = 1'b1;
                end
                else if (do_miss && !table_full)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = next_free_reg[ID_W-1:0];
                end
            end
            ST_LINK:
            begin
                ram_we    = 1'b1;
                ram_wdata = word_reg;
                ram_wdata[HAS_BIT] = 1'b1;
                ram_wdata[NEXT_LSB +: ID_W] = res_id_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            eff_count_reg   <= CNT_W'(EFF_RESET);
            next_free_reg   <= NF_W'(EFF_RESET);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= emit_load || (out_valid_reg && out_stall);
            if (cfg_write)
            begin
                clr_reg <= '0;
                if (position_count > CNT_W'(HOME_DEPTH))
                begin
                    eff_count_reg <= CNT_W'(HOME_DEPTH);
                    next_free_reg <= NF_W'(HOME_DEPTH);
                end
                else
                begin
                    eff_count_reg <= position_count;
                    next_free_reg <= NF_W'(position_count);
                end
            end
            else
            begin
                if (state_reg == ST_CLEAR)
                begin
                    clr_reg <= clr_reg + CLR_W'(1);
                end
                if (do_miss && !table_full)
                begin
                    next_free_reg <= next_free_reg + NF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg <= pos_index;
            uv_reg  <= uv_index;
            nrm_reg <= normal_index;
            cur_reg <= ID_W'(pos_index);
            if (!in_range)
            begin
                res_id_reg      <= '0;
                res_created_reg <= 1'b0;
                res_status_reg  <= STATUS_RANGE;
            end
        end
        if (do_claim || do_hit)
        begin
            res_id_reg      <= cur_reg;
            res_created_reg <= 1'b0;
            res_status_reg  <= STATUS_OK;
        end
        if (do_follow)
        begin
            cur_reg <= ram_rdata[NEXT_LSB +: ID_W];
        end
        if (do_miss)
        begin
            word_reg <= ram_rdata;
            if (table_full)
            begin
                res_id_reg      <= '0;
                res_created_reg <= 1'b0;
                res_status_reg  <= STATUS_FULL;
            end
            else
            begin
                res_id_reg      <= next_free_reg[ID_W-1:0];
                res_created_reg <= 1'b1;
                res_status_reg  <= STATUS_OK;
            end
        end
        if (emit_load)
        begin
            out_id_reg      <= res_id_reg;
            out_created_reg <= res_created_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign vertex_id = out_id_reg;
    assign created   = out_created_reg;
    assign status    = out_status_reg;

endmodule

### sv/vitd_ram.sv
module vitd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/vitd_checker.sv
module vitd_checker #(
    parameter int ID_W = 13
) (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input logic            out_valid,
    input logic            out_stall,
    input logic [ID_W-1:0] vertex_id,
    input logic            created,
    input logic [1:0]      status
);

    import vitd_pkg::*;

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex_id) && $stable(created)
                                   && $stable(status))
        else $error("stalled result changed");

    // One request is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while busy");

    // Error results carry no vertex.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_RANGE || status == STATUS_FULL)
            |-> vertex_id == '0 && !created)
        else $error("error result carries a vertex");

    // An appended vertex is always a success.
    a_created_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && created |-> status == STATUS_OK)
        else $error("created flag with error status");

endmodule

bind vertex_index_triple_dedup vitd_checker #(
    .ID_W ($clog2(MAX_VERTICES))
) u_vitd_checker (.*);
